/* design/gn2_pkg.sv */
// Shared types and fixed-point constants of the 2D gradient noise block.
`timescale 1ns / 1ps
package gn2_pkg;

   // Request kinds carried on req_type.
   typedef enum logic [1:0] {
      REQ_PERM = 2'd0,
      REQ_GRAD = 2'd1,
      REQ_EVAL = 2'd2
   } req_kind_type;

   localparam int FRAC_BITS = 16;
   localparam logic [16:0] ONE_Q16   = 17'h10000;
   localparam logic [17:0] THREE_Q16 = 18'd196608;

endpackage

/* design/gn2_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
`timescale 1ns / 1ps
module gn2_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a_ff,
   output logic [WIDTH-1:0]         rd_data_b_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

endmodule

/* design/gradient_noise_2d.sv */
// Top level of the pipelined 2D gradient noise evaluator.
`timescale 1ns / 1ps
// The block takes one request per clock while the output is not held back and
// returns one noise sample for every evaluate request. Load requests write the
// permutation and gradient tables and give no result; a load is applied at the
// pipeline stage where its table is read, so any evaluate request accepted after
// a load sees it, with no gap needed. The tables are replicated two-port RAMs
// (one permutation copy for the first hash level, two for the second, two for
// each gradient component), which is what lets all lookups of one level, among
// them the eight gradient lookups of a sample, happen in the same cycle.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module gradient_noise_2d
   import gn2_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [7:0]         req_entry_index,
   input  logic [7:0]         req_perm_value,
   input  logic [16:0]        req_grad_x_value,
   input  logic [16:0]        req_grad_y_value,
   input  logic [23:0]        req_coord_x,
   input  logic [23:0]        req_coord_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [18:0] rsp_noise_value
);

   localparam int AW = $clog2(TABLE_DEPTH);

   // Reduces an 8-bit index modulo the table depth (quotient below sixteen).
   function automatic logic [AW-1:0] tbl_index(input logic [7:0] v);
      logic [15:0] r;
      begin
         r = {8'd0, v};
         for (int k = 3; k >= 0; k--) begin
            if (r >= 16'(TABLE_DEPTH << k)) begin
               r = r - 16'(TABLE_DEPTH << k);
            end
         end
         return r[AW-1:0];
      end
   endfunction

   logic adv;
   logic accept;
   req_kind_type in_kind;

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;
   assign accept    = req_valid && req_ready;
   assign in_kind   = req_kind_type'(req_type);

   // ---------------- stage 0: first hash level, weight part one
   logic [7:0]  qx0, qx1;
   logic [15:0] in_tx, in_ty;
   logic [17:0] sx, sy;
   logic [33:0] sx_prod, sy_prod;

   assign qx0     = req_coord_x[23:16];
   assign qx1     = qx0 + 8'd1;
   assign in_tx   = req_coord_x[15:0];
   assign in_ty   = req_coord_y[15:0];
   assign sx      = THREE_Q16 - {1'b0, in_tx, 1'b0};
   assign sy      = THREE_Q16 - {1'b0, in_ty, 1'b0};
   assign sx_prod = sx * in_tx;
   assign sy_prod = sy * in_ty;

   logic [7:0] pa, pb;

   gn2_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_perm1 (
      .clock(clock),
      .wr_en(adv && accept && in_kind == REQ_PERM),
      .wr_addr(tbl_index(req_entry_index)),
      .wr_data(req_perm_value),
      .rd_en(adv),
      .rd_addr_a(tbl_index(qx0)),
      .rd_addr_b(tbl_index(qx1)),
      .rd_data_a_ff(pa),
      .rd_data_b_ff(pb)
   );

   logic         s1_vld_ff;
   req_kind_type s1_kind_ff;
   logic [AW-1:0] s1_index_ff;
   logic [7:0]   s1_perm_ff, s1_qy0_ff;
   logic [16:0]  s1_gx_ff, s1_gy_ff;
   logic [15:0]  s1_tx_ff, s1_ty_ff;
   logic [17:0]  s1_ax_ff, s1_ay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= accept;
      end
      if (adv) begin
         s1_kind_ff  <= in_kind;
         s1_index_ff <= tbl_index(req_entry_index);
         s1_perm_ff  <= req_perm_value;
         s1_gx_ff    <= req_grad_x_value;
         s1_gy_ff    <= req_grad_y_value;
         s1_qy0_ff   <= req_coord_y[23:16];
         s1_tx_ff    <= in_tx;
         s1_ty_ff    <= in_ty;
         s1_ax_ff    <= sx_prod[33:16];
         s1_ay_ff    <= sy_prod[33:16];
      end
   end

   // ---------------- stage 1: second hash level, weight part two
   logic [7:0]  qy1;
   logic [33:0] wx_prod, wy_prod;
   logic [7:0]  h00, h10, h01, h11;
   logic        perm2_wr;

   assign qy1      = s1_qy0_ff + 8'd1;
   assign wx_prod  = s1_ax_ff * s1_tx_ff;
   assign wy_prod  = s1_ay_ff * s1_ty_ff;
   assign perm2_wr = adv && s1_vld_ff && s1_kind_ff == REQ_PERM;

   gn2_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_perm2a (
      .clock(clock),
      .wr_en(perm2_wr),
      .wr_addr(s1_index_ff),
      .wr_data(s1_perm_ff),
      .rd_en(adv),
      .rd_addr_a(tbl_index(s1_qy0_ff + pa)),
      .rd_addr_b(tbl_index(qy1 + pa)),
      .rd_data_a_ff(h00),
      .rd_data_b_ff(h10)
   );

   gn2_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_perm2b (
      .clock(clock),
      .wr_en(perm2_wr),
      .wr_addr(s1_index_ff),
      .wr_data(s1_perm_ff),
      .rd_en(adv),
      .rd_addr_a(tbl_index(s1_qy0_ff + pb)),
      .rd_addr_b(tbl_index(qy1 + pb)),
      .rd_data_a_ff(h01),
      .rd_data_b_ff(h11)
   );

   logic         s2_vld_ff;
   req_kind_type s2_kind_ff;
   logic [AW-1:0] s2_index_ff;
   logic [16:0]  s2_gx_ff, s2_gy_ff;
   logic [15:0]  s2_tx_ff, s2_ty_ff;
   logic [16:0]  s2_wx_ff, s2_wy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (adv) begin
         s2_kind_ff  <= s1_kind_ff;
         s2_index_ff <= s1_index_ff;
         s2_gx_ff    <= s1_gx_ff;
         s2_gy_ff    <= s1_gy_ff;
         s2_tx_ff    <= s1_tx_ff;
         s2_ty_ff    <= s1_ty_ff;
         s2_wx_ff    <= wx_prod[32:16];
         s2_wy_ff    <= wy_prod[32:16];
      end
   end

   // ---------------- stage 2: gradient lookups
   logic        grad_wr;
   logic [16:0] gx00, gx10, gx01, gx11, gy00, gy10, gy01, gy11;

   assign grad_wr = adv && s2_vld_ff && s2_kind_ff == REQ_GRAD;

   gn2_ram #(.WIDTH(17), .DEPTH(TABLE_DEPTH)) u_gxa (
      .clock(clock), .wr_en(grad_wr), .wr_addr(s2_index_ff), .wr_data(s2_gx_ff),
      .rd_en(adv), .rd_addr_a(tbl_index(h00)), .rd_addr_b(tbl_index(h10)),
      .rd_data_a_ff(gx00), .rd_data_b_ff(gx10)
   );

   gn2_ram #(.WIDTH(17), .DEPTH(TABLE_DEPTH)) u_gxb (
      .clock(clock), .wr_en(grad_wr), .wr_addr(s2_index_ff), .wr_data(s2_gx_ff),
      .rd_en(adv), .rd_addr_a(tbl_index(h01)), .rd_addr_b(tbl_index(h11)),
      .rd_data_a_ff(gx01), .rd_data_b_ff(gx11)
   );

   gn2_ram #(.WIDTH(17), .DEPTH(TABLE_DEPTH)) u_gya (
      .clock(clock), .wr_en(grad_wr), .wr_addr(s2_index_ff), .wr_data(s2_gy_ff),
      .rd_en(adv), .rd_addr_a(tbl_index(h00)), .rd_addr_b(tbl_index(h10)),
      .rd_data_a_ff(gy00), .rd_data_b_ff(gy10)
   );

   gn2_ram #(.WIDTH(17), .DEPTH(TABLE_DEPTH)) u_gyb (
      .clock(clock), .wr_en(grad_wr), .wr_addr(s2_index_ff), .wr_data(s2_gy_ff),
      .rd_en(adv), .rd_addr_a(tbl_index(h01)), .rd_addr_b(tbl_index(h11)),
      .rd_data_a_ff(gy01), .rd_data_b_ff(gy11)
   );

   logic        s3_vld_ff;
   logic [15:0] s3_tx_ff, s3_ty_ff;
   logic [16:0] s3_wx_ff, s3_wy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff && s2_kind_ff == REQ_EVAL;
      end
      if (adv) begin
         s3_tx_ff <= s2_tx_ff;
         s3_ty_ff <= s2_ty_ff;
         s3_wx_ff <= s2_wx_ff;
         s3_wy_ff <= s2_wy_ff;
      end
   end

   // ---------------- stage 3: gradient by offset products
   logic signed [17:0] ox0, ox1, oy0, oy1;
   logic signed [35:0] mx00, mx01, mx10, mx11, my00, my01, my10, my11;

   assign ox0 = $signed({2'b00, s3_tx_ff});
   assign oy0 = $signed({2'b00, s3_ty_ff});
   assign ox1 = ox0 - $signed({1'b0, ONE_Q16});
   assign oy1 = oy0 - $signed({1'b0, ONE_Q16});

   assign mx00 = $signed({1'b0, gx00}) * ox0;
   assign my00 = $signed({1'b0, gy00}) * oy0;
   assign mx01 = $signed({1'b0, gx01}) * ox1;
   assign my01 = $signed({1'b0, gy01}) * oy0;
   assign mx10 = $signed({1'b0, gx10}) * ox0;
   assign my10 = $signed({1'b0, gy10}) * oy1;
   assign mx11 = $signed({1'b0, gx11}) * ox1;
   assign my11 = $signed({1'b0, gy11}) * oy1;

   logic               s4_vld_ff;
   logic signed [19:0] s4_px00_ff, s4_px01_ff, s4_px10_ff, s4_px11_ff;
   logic signed [19:0] s4_py00_ff, s4_py01_ff, s4_py10_ff, s4_py11_ff;
   logic [16:0]        s4_wx_ff, s4_wy_ff;

   // Keeping the upper bits is an arithmetic shift, i.e. rounding toward minus infinity.
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= s3_vld_ff;
      end
      if (adv) begin
         s4_px00_ff <= mx00[35:16];
         s4_px01_ff <= mx01[35:16];
         s4_px10_ff <= mx10[35:16];
         s4_px11_ff <= mx11[35:16];
         s4_py00_ff <= my00[35:16];
         s4_py01_ff <= my01[35:16];
         s4_py10_ff <= my10[35:16];
         s4_py11_ff <= my11[35:16];
         s4_wx_ff   <= s3_wx_ff;
         s4_wy_ff   <= s3_wy_ff;
      end
   end

   // ---------------- stage 4: corner values and x differences
   logic signed [20:0] v00, v01, v10, v11;

   assign v00 = 21'(s4_px00_ff) + 21'(s4_py00_ff);
   assign v01 = 21'(s4_px01_ff) + 21'(s4_py01_ff);
   assign v10 = 21'(s4_px10_ff) + 21'(s4_py10_ff);
   assign v11 = 21'(s4_px11_ff) + 21'(s4_py11_ff);

   logic               s5_vld_ff;
   logic signed [20:0] s5_v00_ff, s5_v10_ff;
   logic signed [21:0] s5_d0_ff, s5_d1_ff;
   logic [16:0]        s5_wx_ff, s5_wy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (adv) begin
         s5_vld_ff <= s4_vld_ff;
      end
      if (adv) begin
         s5_v00_ff <= v00;
         s5_v10_ff <= v10;
         s5_d0_ff  <= 22'(v00) - 22'(v01);
         s5_d1_ff  <= 22'(v10) - 22'(v11);
         s5_wx_ff  <= s4_wx_ff;
         s5_wy_ff  <= s4_wy_ff;
      end
   end

   // ---------------- stage 5: x blend products
   logic signed [39:0] bx0, bx1;

   assign bx0 = $signed({1'b0, s5_wx_ff}) * s5_d0_ff;
   assign bx1 = $signed({1'b0, s5_wx_ff}) * s5_d1_ff;

   logic               s6_vld_ff;
   logic signed [20:0] s6_v00_ff, s6_v10_ff;
   logic signed [23:0] s6_m0_ff, s6_m1_ff;
   logic [16:0]        s6_wy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (adv) begin
         s6_vld_ff <= s5_vld_ff;
      end
      if (adv) begin
         s6_v00_ff <= s5_v00_ff;
         s6_v10_ff <= s5_v10_ff;
         s6_m0_ff  <= bx0[39:16];
         s6_m1_ff  <= bx1[39:16];
         s6_wy_ff  <= s5_wy_ff;
      end
   end

   // ---------------- stage 6: x blend and y difference
   logic signed [24:0] v0, v1;

   assign v0 = 25'(s6_v00_ff) - 25'(s6_m0_ff);
   assign v1 = 25'(s6_v10_ff) - 25'(s6_m1_ff);

   logic               s7_vld_ff;
   logic signed [24:0] s7_v0_ff;
   logic signed [25:0] s7_dy_ff;
   logic [16:0]        s7_wy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else if (adv) begin
         s7_vld_ff <= s6_vld_ff;
      end
      if (adv) begin
         s7_v0_ff <= v0;
         s7_dy_ff <= 26'(v0) - 26'(v1);
         s7_wy_ff <= s6_wy_ff;
      end
   end

   // ---------------- stage 7: y blend product
   logic signed [43:0] by;

   assign by = $signed({1'b0, s7_wy_ff}) * s7_dy_ff;

   logic               s8_vld_ff;
   logic signed [24:0] s8_v0_ff;
   logic signed [27:0] s8_m_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_vld_ff <= 1'b0;
      end else if (adv) begin
         s8_vld_ff <= s7_vld_ff;
      end
      if (adv) begin
         s8_v0_ff <= s7_v0_ff;
         s8_m_ff  <= by[43:16];
      end
   end

   // ---------------- stage 8: final blend, saturation, output register
   logic signed [28:0] v_full;
   logic signed [18:0] v_sat;

   assign v_full = 29'(s8_v0_ff) - 29'(s8_m_ff);

   // The value fits when all bits above the result's sign bit agree with it.
   always_comb begin
      if (v_full[28:18] == {11{1'b0}} || v_full[28:18] == {11{1'b1}}) begin
         v_sat = v_full[18:0];
      end else if (v_full[28]) begin
         v_sat = {1'b1, 18'd0};
      end else begin
         v_sat = {1'b0, {18{1'b1}}};
      end
   end

   logic               rsp_valid_ff;
   logic signed [18:0] rsp_noise_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s8_vld_ff;
      end
      if (adv) begin
         rsp_noise_ff <= v_sat;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_ff;

   // ---------------- assertions
   logic [8:0] pipe_vld;

   assign pipe_vld = {s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff,
                      s6_vld_ff, s7_vld_ff, s8_vld_ff, rsp_valid_ff};

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(pipe_vld))
      else $error("pipeline valid bits changed during a stall");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      s3_vld_ff |-> (s3_wx_ff <= ONE_Q16 && s3_wy_ff <= ONE_Q16))
      else $error("smoothstep weight above one");

   a_last_stage_moves: assert property (@(posedge clock) disable iff (reset)
      adv && s8_vld_ff |=> rsp_valid)
      else $error("finished sample did not reach the output");

   a_load_gives_no_result: assert property (@(posedge clock) disable iff (reset)
      adv && s2_vld_ff && s2_kind_ff != REQ_EVAL |=> !s3_vld_ff)
      else $error("load request entered the arithmetic stages");

endmodule

/* sim/gn2_noise_checker.sv */
// Checker for the 2D gradient noise block: table shadow, noise predictor and compare.
`timescale 1ns / 1ps
module gn2_noise_checker
   import gn2_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [7:0]         req_entry_index,
   input  logic [7:0]         req_perm_value,
   input  logic [16:0]        req_grad_x_value,
   input  logic [16:0]        req_grad_y_value,
   input  logic [23:0]        req_coord_x,
   input  logic [23:0]        req_coord_y,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [18:0] rsp_noise_value,
   output int                 fail_count,
   output int                 pending
);

   logic [7:0]  perm_shadow [256];
   logic [16:0] gx_shadow [256];
   logic [16:0] gy_shadow [256];
   logic signed [18:0] noise_expected [$];
   int mismatches;

   function automatic logic [7:0] corner_hash(logic [7:0] cx, logic [7:0] cy);
      logic [7:0] first;
      first = perm_shadow[cx];
      return perm_shadow[8'(cy + first)];
   endfunction

   function automatic longint corner_dot(logic [7:0] q, longint ox, longint oy);
      return ((longint'(gx_shadow[q]) * ox) >>> 16) + ((longint'(gy_shadow[q]) * oy) >>> 16);
   endfunction

   function automatic longint fade_weight(longint t);
      longint a;
      a = ((longint'(THREE_Q16) - 2 * t) * t) >>> 16;
      return (a * t) >>> 16;
   endfunction

   function automatic logic signed [18:0] noise_sample(logic [23:0] x, logic [23:0] y);
      logic [7:0] qx0, qy0, qx1, qy1;
      longint tx0, ty0, tx1, ty1, v00, v01, v10, v11, wx, wy, v0, v1, v;
      qx0 = x[23:16];
      qy0 = y[23:16];
      qx1 = qx0 + 8'd1;
      qy1 = qy0 + 8'd1;
      tx0 = longint'(x[15:0]);
      ty0 = longint'(y[15:0]);
      tx1 = tx0 - longint'(ONE_Q16);
      ty1 = ty0 - longint'(ONE_Q16);
      v00 = corner_dot(corner_hash(qx0, qy0), tx0, ty0);
      v01 = corner_dot(corner_hash(qx1, qy0), tx1, ty0);
      v10 = corner_dot(corner_hash(qx0, qy1), tx0, ty1);
      v11 = corner_dot(corner_hash(qx1, qy1), tx1, ty1);
      wx = fade_weight(tx0);
      wy = fade_weight(ty0);
      v0 = v00 - ((wx * (v00 - v01)) >>> 16);
      v1 = v10 - ((wx * (v10 - v11)) >>> 16);
      v = v0 - ((wy * (v0 - v1)) >>> 16);
      if (v > 262143) v = 262143;
      if (v < -262144) v = -262144;
      return 19'(v);
   endfunction

   always @(posedge clock) begin
      logic signed [18:0] want;
      if (reset) begin
         fail_count <= 0;
         mismatches = 0;
         noise_expected.delete();
      end else begin
         if (req_valid && req_ready) begin
            if (req_type == REQ_PERM) begin
               perm_shadow[req_entry_index] = req_perm_value;
            end else if (req_type == REQ_GRAD) begin
               gx_shadow[req_entry_index] = req_grad_x_value;
               gy_shadow[req_entry_index] = req_grad_y_value;
            end else if (req_type == REQ_EVAL) begin
               noise_expected.push_back(noise_sample(req_coord_x, req_coord_y));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (noise_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected noise transfer: got %0d", rsp_noise_value);
            end else begin
               want = noise_expected.pop_front();
               if (want !== rsp_noise_value) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("noise mismatch: expected %0d, got %0d", want, rsp_noise_value);
               end
            end
         end
         fail_count <= mismatches;
      end
      pending <= noise_expected.size();
   end

endmodule

/* sim/tb_gradient_noise_2d.sv */
// Testbench top for the 2D gradient noise block: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb_gradient_noise_2d;
   import gn2_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_type = REQ_PERM;
   logic [7:0]         req_entry_index = '0;
   logic [7:0]         req_perm_value = '0;
   logic [16:0]        req_grad_x_value = '0;
   logic [16:0]        req_grad_y_value = '0;
   logic [23:0]        req_coord_x = '0;
   logic [23:0]        req_coord_y = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [18:0] rsp_noise_value;
   int                 fail_count;
   int                 pending;

   bit no_idle = 1'b0;
   int eval_sent = 0;
   int load_sent = 0;
   int sink_hold = 0;

   always #5 clock = ~clock;

   gradient_noise_2d u_dut (.*);

   gn2_noise_checker u_checker (.*);

   // The receiver draws a fresh stall after every transfer.
   always @(posedge clock) begin
      logic ready_next;
      if (reset) begin
         ready_next = 1'b0;
         sink_hold = 0;
      end else if (sink_hold > 0) begin
         sink_hold--;
         ready_next = 1'b0;
      end else begin
         ready_next = 1'b1;
         if (rsp_valid && rsp_ready) begin
            sink_hold = no_idle ? 0 : $urandom_range(0, 10);
            if (sink_hold > 0) begin
               sink_hold--;
               ready_next = 1'b0;
            end
         end
      end
      rsp_ready <= ready_next;
   end

   task automatic send_req(logic [1:0] kind, logic [7:0] idx, logic [7:0] pv,
                           logic [16:0] gx, logic [16:0] gy,
                           logic [23:0] cx, logic [23:0] cy);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_entry_index  <= idx;
      req_perm_value   <= pv;
      req_grad_x_value <= gx;
      req_grad_y_value <= gy;
      req_coord_x      <= cx;
      req_coord_y      <= cy;
      do @(posedge clock); while (!req_ready);
      if (kind == REQ_EVAL) eval_sent++;
      else if (kind != REQ_UNUSED) load_sent++;
   endtask

   task automatic send_eval(logic [23:0] cx, logic [23:0] cy);
      send_req(REQ_EVAL, 8'($urandom), 8'($urandom), 17'($urandom), 17'($urandom), cx, cy);
   endtask

   initial begin
      logic [16:0] gx, gy;
      int pick;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every entry is loaded before the first evaluate, so no unwritten read happens.
      for (int i = 0; i < 256; i++)
         send_req(REQ_PERM, 8'(i), 8'(i * 167 + 13), 17'($urandom), 17'($urandom),
                  24'($urandom), 24'($urandom));
      for (int i = 0; i < 256; i++) begin
         case (i % 4)
            0: begin gx = 17'd0; gy = 17'h10000; end
            1: begin gx = 17'h10000; gy = 17'd0; end
            2: begin gx = 17'h1ffff; gy = 17'h1ffff; end
            default: begin gx = 17'($urandom); gy = 17'($urandom); end
         endcase
         send_req(REQ_GRAD, 8'(i), 8'($urandom), gx, gy, 24'($urandom), 24'($urandom));
      end

      send_eval(24'h000000, 24'h000000);
      send_eval(24'hffffff, 24'hffffff);
      send_eval(24'h00ffff, 24'hff0000);
      send_eval(24'hff0000, 24'h00ffff);
      send_eval(24'h008000, 24'h008000);
      send_eval(24'hff8000, 24'h7f0001);
      send_req(REQ_UNUSED, 8'hff, 8'hff, 17'h1ffff, 17'h1ffff, 24'hffffff, 24'hffffff);
      send_req(REQ_PERM, 8'hff, 8'h00, 17'h0, 17'h0, 24'h0, 24'h0);
      send_eval(24'hfe4000, 24'h01c000);
      send_req(REQ_GRAD, 8'h00, 8'h0, 17'h1ffff, 17'h00000, 24'h0, 24'h0);
      send_eval(24'h00ffff, 24'h00ffff);

      // The sender holds off until the pipeline has drained completely.
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      @(posedge clock);

      for (int n = 0; n < 280; n++) begin
         if (n % 100 == 0) no_idle = ($urandom_range(0, 2) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 75)
            send_eval(24'($urandom), 24'($urandom));
         else if (pick < 85)
            send_req(REQ_PERM, 8'($urandom), 8'($urandom), 17'($urandom), 17'($urandom),
                     24'($urandom), 24'($urandom));
         else if (pick < 95)
            send_req(REQ_GRAD, 8'($urandom), 8'($urandom), 17'($urandom), 17'($urandom),
                     24'($urandom), 24'($urandom));
         else
            send_req(REQ_UNUSED, 8'($urandom), 8'($urandom), 17'($urandom), 17'($urandom),
                     24'($urandom), 24'($urandom));
      end
      req_valid <= 1'b0;
      no_idle = 1'b0;

      @(posedge clock);
      wait (pending == 0);
      repeat (20) @(posedge clock);
      $display("Covered %0d noise evaluations and %0d table loads under random gaps and stalls.",
               eval_sent, load_sent);
      if (fail_count == 0)
         $display("tb_gradient_noise_2d passed");
      else
         $display("tb_gradient_noise_2d failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_gradient_noise_2d failed");
      $finish;
   end

endmodule
